// File: hdl/throw_arm_sequencer_assert.svh
// Assertion macros for the throw arm sequencer.
// Included by the top level; depends on nothing else.
`ifndef THROW_ARM_SEQUENCER_ASSERT_SVH
`define THROW_ARM_SEQUENCER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("throw arm sequencer: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("throw arm sequencer: next-cycle check failed");

`endif

// File: hdl/tas_pkg.sv
// Shared types and constants of the throw arm sequencer.
// Used by the controller, the datapath, the divider, the top level and the testbench.
package tas_pkg;

  // Order codes
  localparam logic [1:0] ORD_STOP   = 2'd0;
  localparam logic [1:0] ORD_LOAD   = 2'd1;
  localparam logic [1:0] ORD_LAUNCH = 2'd2;
  localparam logic [1:0] ORD_HOLD   = 2'd3;

  // Loading steps
  localparam logic [1:0] LD_GRIP  = 2'd0;
  localparam logic [1:0] LD_CLOSE = 2'd1;
  localparam logic [1:0] LD_LIFT  = 2'd2;
  localparam logic [1:0] LD_DONE  = 2'd3;

  // Launch steps
  localparam logic [2:0] LN_DRIVE  = 3'd0;
  localparam logic [2:0] LN_RAMP   = 3'd1;
  localparam logic [2:0] LN_RETURN = 3'd2;
  localparam logic [2:0] LN_SLOW   = 3'd3;
  localparam logic [2:0] LN_DONE   = 3'd4;

  // Solenoid commands
  localparam logic [1:0] SOL_OFF   = 2'd0;
  localparam logic [1:0] SOL_FIRE  = 2'd1;
  localparam logic [1:0] SOL_CLOSE = 2'd2;

  // Motor modes
  localparam logic MODE_OPEN = 1'b0;
  localparam logic MODE_HOLD = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_PICK    = 3'd0;
  localparam logic [2:0] REG_LIFT    = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_FWD     = 3'd3;
  localparam logic [2:0] REG_SLOW    = 3'd4;
  localparam logic [2:0] REG_HOME    = 3'd5;
  localparam logic [2:0] REG_LDRIVE  = 3'd6;
  localparam logic [2:0] REG_RDRIVE  = 3'd7;

  // Configuration reset values
  localparam logic signed [15:0] RST_PICK    = -16'sd75;
  localparam logic signed [15:0] RST_LIFT    = -16'sd90;
  localparam logic signed [15:0] RST_RELEASE = 16'sd470;
  localparam logic signed [15:0] RST_FWD     = 16'sd720;
  localparam logic signed [15:0] RST_SLOW    = 16'sd260;
  localparam logic signed [15:0] RST_HOME    = 16'sd60;
  localparam logic [7:0]         RST_LDRIVE  = 8'd120;
  localparam logic [7:0]         RST_RDRIVE  = 8'd90;

  // Arm state reset values
  localparam logic signed [15:0] RST_SETPOINT = -16'sd75;
  localparam logic signed [15:0] RST_DRIVE    = 16'sd120;

  // Safety window and lift hold length
  localparam logic signed [15:0] SAFE_HIGH  = 16'sd1200;
  localparam logic signed [15:0] SAFE_LOW   = -16'sd1200;
  localparam logic [7:0]         LIFT_TICKS = 8'd30;

  // Ramp divider widths: numerator is a 17 x 9 bit product, divisor a 17 bit difference
  localparam int NUM_W  = 26;
  localparam int DEN_W  = 17;
  localparam int NMAG_W = 25;
  localparam int Q_W    = 16;
  localparam int CNT_W  = $clog2(NMAG_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_APPLY
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic prep;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

// File: hdl/tas_stream_if.sv
// Valid/ready channels of the throw arm sequencer: tick words in, command words out.
// Depends on nothing but the plain field widths.
interface tas_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic               order_valid;
  logic [1:0]         new_order;

  modport source (output valid, angle, order_valid, new_order, input ready);
  modport sink   (input valid, angle, order_valid, new_order, output ready);
endinterface

interface tas_out_if;
  logic               valid;
  logic               ready;
  logic               motor_mode;
  logic signed [15:0] target_angle;
  logic signed [15:0] drive;
  logic [1:0]         solenoid_cmd;
  logic [1:0]         load_step;
  logic [2:0]         launch_step;
  logic [7:0]         lift_ticks;

  modport source (output valid, motor_mode, target_angle, drive, solenoid_cmd,
                  load_step, launch_step, lift_ticks, input ready);
  modport sink   (input valid, motor_mode, target_angle, drive, solenoid_cmd,
                  load_step, launch_step, lift_ticks, output ready);
endinterface

// File: hdl/tas_divider.sv
// Serial signed divider for the drive ramps, one quotient bit per cycle.
// Quotient truncates toward zero, saturates to 16 bits, zero divisor gives 0. Uses tas_pkg.
module tas_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [tas_pkg::NUM_W-1:0] num_i,
  input  logic signed [tas_pkg::DEN_W-1:0] den_i,
  output logic                             done_o,
  output logic signed [tas_pkg::Q_W-1:0]   quo_o
);

  localparam int NMAG_W = tas_pkg::NMAG_W;
  localparam int DEN_W  = tas_pkg::DEN_W;
  localparam int CNT_W  = tas_pkg::CNT_W;
  localparam int Q_W    = tas_pkg::Q_W;
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(NMAG_W - 1);
  localparam logic [NMAG_W-1:0] POS_MAX  = NMAG_W'(2 ** (Q_W - 1) - 1);
  localparam logic [NMAG_W-1:0] NEG_MAX  = NMAG_W'(2 ** (Q_W - 1));
  localparam logic [Q_W-1:0]    Q_POS    = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0]    Q_NEG    = {1'b1, {(Q_W - 1){1'b0}}};

  logic [tas_pkg::NUM_W-1:0] num_abs;
  logic [DEN_W-1:0]          den_abs;
  logic [DEN_W:0]            trial;
  logic                      fits;

  logic [NMAG_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  dmag_q, dmag_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  assign num_abs = num_i[tas_pkg::NUM_W-1] ? -num_i : num_i;
  assign den_abs = den_i[DEN_W-1] ? -den_i : den_i;

  // Shift in the next numerator bit and try a subtract
  assign trial = {rem_q, quo_q[NMAG_W-1]};
  assign fits  = (trial >= {1'b0, dmag_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_abs[NMAG_W-1:0];
      rem_d  = '0;
      dmag_d = den_abs;
      cnt_d  = '0;
      neg_d  = num_i[tas_pkg::NUM_W-1] ^ den_i[DEN_W-1];
      zero_d = (den_i == '0);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, dmag_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NMAG_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_CNT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // Apply sign and saturate the magnitude
  always_comb begin
    priority if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (quo_q > NEG_MAX) ? Q_NEG : (~quo_q[Q_W-1:0] + Q_W'(1));
    end else begin
      quo_o = (quo_q > POS_MAX) ? Q_POS : quo_q[Q_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: hdl/tas_datapath.sv
// Datapath of the throw arm sequencer: configuration, arm state, ramp operands, divider.
// Driven by tas_ctrl through dp_cmd_t; uses tas_pkg and tas_divider.
module tas_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic signed [15:0]    angle_i,
  input  logic                  order_valid_i,
  input  logic [1:0]            new_order_i,
  input  tas_pkg::dp_cmd_t      cmd_i,
  output tas_pkg::dp_sts_t      sts_o,
  output logic                  motor_mode_o,
  output logic signed [15:0]    target_angle_o,
  output logic signed [15:0]    drive_o,
  output logic [1:0]            solenoid_cmd_o,
  output logic [1:0]            load_step_o,
  output logic [2:0]            launch_step_o,
  output logic [7:0]            lift_ticks_o
);

  // Configuration registers
  logic signed [15:0] pick_q, lift_q, rel_q, fwd_q, slow_q, home_q;
  logic [7:0]         ldrv_q, rdrv_q;

  // Latched tick word
  logic signed [15:0] ang_q;
  logic [1:0]         ord_q;

  // Ramp operands
  logic signed [tas_pkg::NUM_W-1:0] num_q;
  logic signed [tas_pkg::DEN_W-1:0] den_q;
  logic signed [15:0]               ramp_start, ramp_end;
  logic signed [16:0]               ramp_diff;
  logic signed [8:0]                ldrv_s;
  logic signed [tas_pkg::NUM_W-1:0] num_d;
  logic signed [tas_pkg::DEN_W-1:0] den_d;
  logic signed [tas_pkg::Q_W-1:0]   quo;
  logic                             div_done;

  // Arm state, also the result word
  logic [1:0]         cur_q, cur_d;
  logic [1:0]         ldph_q, ldph_d;
  logic [2:0]         lnph_q, lnph_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [7:0]         cnt_inc;
  logic               mode_q, mode_d;
  logic signed [15:0] sp_q, sp_d;
  logic signed [15:0] drv_q, drv_d;
  logic [1:0]         sol_q, sol_d;
  logic               stop;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= tas_pkg::RST_PICK;
      lift_q <= tas_pkg::RST_LIFT;
      rel_q  <= tas_pkg::RST_RELEASE;
      fwd_q  <= tas_pkg::RST_FWD;
      slow_q <= tas_pkg::RST_SLOW;
      home_q <= tas_pkg::RST_HOME;
      ldrv_q <= tas_pkg::RST_LDRIVE;
      rdrv_q <= tas_pkg::RST_RDRIVE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tas_pkg::REG_PICK:    pick_q <= cfg_data_i;
        tas_pkg::REG_LIFT:    lift_q <= cfg_data_i;
        tas_pkg::REG_RELEASE: rel_q  <= cfg_data_i;
        tas_pkg::REG_FWD:     fwd_q  <= cfg_data_i;
        tas_pkg::REG_SLOW:    slow_q <= cfg_data_i;
        tas_pkg::REG_HOME:    home_q <= cfg_data_i;
        tas_pkg::REG_LDRIVE:  ldrv_q <= cfg_data_i[7:0];
        tas_pkg::REG_RDRIVE:  rdrv_q <= cfg_data_i[7:0];
      endcase
    end
  end

  // Latch the tick word with the new order already applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= '0;
      ord_q <= tas_pkg::ORD_STOP;
    end else if (cmd_i.latch) begin
      ang_q <= angle_i;
      ord_q <= order_valid_i ? new_order_i : cur_q;
    end
  end

  // Pick the ramp ends: forward ramp, or return ramp in the slow step
  always_comb begin
    if (lnph_q == tas_pkg::LN_SLOW) begin
      ramp_start = slow_q;
      ramp_end   = home_q;
    end else begin
      ramp_start = rel_q;
      ramp_end   = fwd_q;
    end
    ramp_diff = 17'(ang_q) - 17'(ramp_end);
    ldrv_s    = $signed({1'b0, ldrv_q});
    num_d     = ramp_diff * ldrv_s;
    den_d     = 17'(ramp_start) - 17'(ramp_end);
  end

  // Register the product ahead of the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  tas_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign sts_o.need_div = (ord_q == tas_pkg::ORD_LAUNCH) &&
                          ((lnph_q == tas_pkg::LN_RAMP) || (lnph_q == tas_pkg::LN_SLOW));
  assign sts_o.div_done = div_done;

  // Run one step of the selected sequence, then the safety cut-off
  always_comb begin
    cur_d   = ord_q;
    ldph_d  = ldph_q;
    lnph_d  = lnph_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    sp_d    = sp_q;
    drv_d   = drv_q;
    sol_d   = sol_q;
    stop    = 1'b0;
    cnt_inc = cnt_q + 8'd1;
    unique case (ord_q)
      tas_pkg::ORD_STOP: begin
        stop = 1'b1;
      end
      tas_pkg::ORD_LOAD: begin
        unique case (ldph_q)
          tas_pkg::LD_GRIP: begin
            mode_d = tas_pkg::MODE_HOLD;
            sp_d   = pick_q;
            sol_d  = tas_pkg::SOL_FIRE;
            if (ang_q <= pick_q) begin
              sol_d  = tas_pkg::SOL_OFF;
              ldph_d = tas_pkg::LD_CLOSE;
            end
          end
          tas_pkg::LD_CLOSE: begin
            sol_d  = tas_pkg::SOL_CLOSE;
            ldph_d = tas_pkg::LD_LIFT;
          end
          tas_pkg::LD_LIFT: begin
            mode_d = tas_pkg::MODE_HOLD;
            sp_d   = lift_q;
            cnt_d  = cnt_inc;
            if (cnt_inc >= tas_pkg::LIFT_TICKS) begin
              cnt_d  = '0;
              ldph_d = tas_pkg::LD_DONE;
            end
          end
          tas_pkg::LD_DONE: begin
            stop = 1'b1;
          end
        endcase
      end
      tas_pkg::ORD_LAUNCH: begin
        unique case (lnph_q)
          tas_pkg::LN_DRIVE: begin
            mode_d = tas_pkg::MODE_OPEN;
            drv_d  = $signed({8'd0, ldrv_q});
            if (ang_q >= rel_q) begin
              sol_d  = tas_pkg::SOL_FIRE;
              lnph_d = tas_pkg::LN_RAMP;
            end
          end
          tas_pkg::LN_RAMP: begin
            drv_d = quo;
            if (ang_q >= fwd_q) begin
              sol_d  = tas_pkg::SOL_OFF;
              lnph_d = tas_pkg::LN_RETURN;
            end
          end
          tas_pkg::LN_RETURN: begin
            drv_d = -$signed({8'd0, rdrv_q});
            if (ang_q <= slow_q) begin
              lnph_d = tas_pkg::LN_SLOW;
            end
          end
          tas_pkg::LN_SLOW: begin
            // Negate the return ramp; the most negative value saturates upward
            drv_d = (quo == {1'b1, 15'd0}) ? {1'b0, {15{1'b1}}} : -quo;
            if (ang_q <= home_q) begin
              lnph_d = tas_pkg::LN_DONE;
            end
          end
          default: begin
            stop = 1'b1;
          end
        endcase
      end
      tas_pkg::ORD_HOLD: begin
        // keep everything
      end
    endcase
    if ((ang_q > tas_pkg::SAFE_HIGH) || (ang_q < tas_pkg::SAFE_LOW)) begin
      stop = 1'b1;
    end
    if (stop) begin
      cur_d  = tas_pkg::ORD_STOP;
      mode_d = tas_pkg::MODE_OPEN;
      drv_d  = '0;
      sol_d  = tas_pkg::SOL_OFF;
      ldph_d = tas_pkg::LD_GRIP;
      lnph_d = tas_pkg::LN_DRIVE;
      cnt_d  = '0;
    end
  end

  // Commit the step; these registers are the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= tas_pkg::ORD_STOP;
      ldph_q <= tas_pkg::LD_GRIP;
      lnph_q <= tas_pkg::LN_DRIVE;
      cnt_q  <= '0;
      mode_q <= tas_pkg::MODE_OPEN;
      sp_q   <= tas_pkg::RST_SETPOINT;
      drv_q  <= tas_pkg::RST_DRIVE;
      sol_q  <= tas_pkg::SOL_OFF;
    end else if (cmd_i.commit) begin
      cur_q  <= cur_d;
      ldph_q <= ldph_d;
      lnph_q <= lnph_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      sp_q   <= sp_d;
      drv_q  <= drv_d;
      sol_q  <= sol_d;
    end
  end

  assign motor_mode_o   = mode_q;
  assign target_angle_o = sp_q;
  assign drive_o        = drv_q;
  assign solenoid_cmd_o = sol_q;
  assign load_step_o    = ldph_q;
  assign launch_step_o  = lnph_q;
  assign lift_ticks_o   = cnt_q;

endmodule

// File: hdl/tas_ctrl.sv
// Controller of the throw arm sequencer: steps one tick word through prepare,
// a divide (ramp steps only) and apply, and owns the handshakes. Uses tas_pkg.
module tas_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tas_pkg::dp_sts_t sts_i,
  output tas_pkg::dp_cmd_t cmd_o
);

  tas_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = tas_pkg::ST_PREP;
        end
      end
      tas_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.need_div ? tas_pkg::ST_START : tas_pkg::ST_APPLY;
      end
      tas_pkg::ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = tas_pkg::ST_DIV;
      end
      tas_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = tas_pkg::ST_APPLY;
        end
      end
      tas_pkg::ST_APPLY: begin
        // Hold until the previous result word has left
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = tas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tas_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/throw_arm_sequencer.sv
// Top level of the throw arm sequencer: controller, datapath and channel wiring.
// Uses tas_pkg, tas_stream_if, tas_ctrl, tas_datapath and the assertion macros.
//
//   channel  | dir | words                                     | accepted when
//   ---------+-----+-------------------------------------------+------------------
//   in_i     | in  | angle, order_valid, new_order             | valid && ready
//   out_o    | out | motor_mode, target_angle, drive, solenoid | valid && ready
//            |     | cmd, load_step, launch_step, lift_ticks   |
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i           | cfg_we_i
//
// A tick word passes from acceptance through prepare and apply, and through the
// serial divider's 25 quotient bits as well when the current step is a drive ramp.
// One word is in work at a time; the next is taken while the result waits.
// A result held by a stalled sink delays only the commit of the following word.
// Reset restores the configuration defaults and the idle arm state at once.
`include "throw_arm_sequencer_assert.svh"

module throw_arm_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tas_in_if.sink      in_i,
  tas_out_if.source   out_o
);

  tas_pkg::dp_cmd_t cmd;
  tas_pkg::dp_sts_t sts;
  logic             in_ready;
  logic             out_valid;

  tas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tas_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .angle_i        (in_i.angle),
    .order_valid_i  (in_i.order_valid),
    .new_order_i    (in_i.new_order),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .motor_mode_o   (out_o.motor_mode),
    .target_angle_o (out_o.target_angle),
    .drive_o        (out_o.drive),
    .solenoid_cmd_o (out_o.solenoid_cmd),
    .load_step_o    (out_o.load_step),
    .launch_step_o  (out_o.launch_step),
    .lift_ticks_o   (out_o.lift_ticks)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // One word in work: no second word right after an acceptance
  `TAS_ASSERT_NEXT(a_single_word, clk_i, rst_ni, in_i.valid && in_ready, !in_ready)
  // A commit never overwrites a result that is still waiting
  `TAS_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, cmd.commit, !out_valid || out_o.ready)
  // The divider starts only for a ramp step
  `TAS_ASSERT_NOW(a_div_for_ramp, clk_i, rst_ni, cmd.div_start, sts.need_div)

endmodule

// File: test/throw_arm_sequencer_test.sv
// Testbench for the throw arm sequencer: directed and random control ticks checked
// against a cycle-free model of the arm. Needs tas_pkg, tas_stream_if and the RTL.
`timescale 1ns / 1ps

module throw_arm_sequencer_test;

  // One command word as the block sends it
  typedef struct packed {
    logic               mode;
    logic signed [15:0] target;
    logic signed [15:0] drive;
    logic [1:0]         sol;
    logic [1:0]         load_ph;
    logic [2:0]         launch_ph;
    logic [7:0]         lift;
  } arm_cmd_t;

  // Arm model and the queue of command words still due from the block
  class arm_command_board;
    logic signed [15:0] pick_ang, lift_ang, rel_ang, fwd_ang, slow_ang, home_ang;
    logic [7:0]         launch_drv, return_drv;
    logic [1:0]         order;
    logic [1:0]         load_ph;
    logic [2:0]         launch_ph;
    logic [7:0]         lift_cnt;
    logic               mode;
    logic signed [15:0] setpoint, drive;
    logic [1:0]         sol;
    arm_cmd_t           due_cmds[$];
    int                 errors;
    int                 checked;

    function new();
      pick_ang   = tas_pkg::RST_PICK;
      lift_ang   = tas_pkg::RST_LIFT;
      rel_ang    = tas_pkg::RST_RELEASE;
      fwd_ang    = tas_pkg::RST_FWD;
      slow_ang   = tas_pkg::RST_SLOW;
      home_ang   = tas_pkg::RST_HOME;
      launch_drv = tas_pkg::RST_LDRIVE;
      return_drv = tas_pkg::RST_RDRIVE;
      order      = tas_pkg::ORD_STOP;
      load_ph    = tas_pkg::LD_GRIP;
      launch_ph  = tas_pkg::LN_DRIVE;
      lift_cnt   = 8'd0;
      mode       = tas_pkg::MODE_OPEN;
      setpoint   = tas_pkg::RST_SETPOINT;
      drive      = tas_pkg::RST_DRIVE;
      sol        = tas_pkg::SOL_OFF;
      errors     = 0;
      checked    = 0;
    endfunction

    function int pending();
      return due_cmds.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        tas_pkg::REG_PICK:    pick_ang = data;
        tas_pkg::REG_LIFT:    lift_ang = data;
        tas_pkg::REG_RELEASE: rel_ang = data;
        tas_pkg::REG_FWD:     fwd_ang = data;
        tas_pkg::REG_SLOW:    slow_ang = data;
        tas_pkg::REG_HOME:    home_ang = data;
        tas_pkg::REG_LDRIVE:  launch_drv = data[7:0];
        tas_pkg::REG_RDRIVE:  return_drv = data[7:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    // Linear drive ramp, truncated toward zero; a flat ramp gives no drive
    function logic signed [15:0] ramp_drive(logic signed [15:0] a,
                                            logic signed [15:0] from_ang,
                                            logic signed [15:0] to_ang);
      longint span, lead;
      span = longint'(from_ang) - longint'(to_ang);
      lead = (longint'(a) - longint'(to_ang)) * longint'(launch_drv);
      if (span == 0) return 16'sd0;
      return clamp16(lead / span);
    endfunction

    // Drop every sequence back to rest; the setpoint is kept
    function void clear_arm();
      order     = tas_pkg::ORD_STOP;
      mode      = tas_pkg::MODE_OPEN;
      drive     = 16'sd0;
      sol       = tas_pkg::SOL_OFF;
      load_ph   = tas_pkg::LD_GRIP;
      launch_ph = tas_pkg::LN_DRIVE;
      lift_cnt  = 8'd0;
    endfunction

    function void load_tick(logic signed [15:0] a);
      case (load_ph)
        tas_pkg::LD_GRIP: begin
          mode     = tas_pkg::MODE_HOLD;
          setpoint = pick_ang;
          sol      = tas_pkg::SOL_FIRE;
          if (a <= pick_ang) begin
            sol     = tas_pkg::SOL_OFF;
            load_ph = tas_pkg::LD_CLOSE;
          end
        end
        tas_pkg::LD_CLOSE: begin
          sol     = tas_pkg::SOL_CLOSE;
          load_ph = tas_pkg::LD_LIFT;
        end
        tas_pkg::LD_LIFT: begin
          mode     = tas_pkg::MODE_HOLD;
          setpoint = lift_ang;
          lift_cnt = lift_cnt + 8'd1;
          if (lift_cnt >= tas_pkg::LIFT_TICKS) begin
            lift_cnt = 8'd0;
            load_ph  = tas_pkg::LD_DONE;
          end
        end
        default: clear_arm();
      endcase
    endfunction

    function void launch_tick(logic signed [15:0] a);
      case (launch_ph)
        tas_pkg::LN_DRIVE: begin
          mode  = tas_pkg::MODE_OPEN;
          drive = 16'(launch_drv);
          if (a >= rel_ang) begin
            sol       = tas_pkg::SOL_FIRE;
            launch_ph = tas_pkg::LN_RAMP;
          end
        end
        tas_pkg::LN_RAMP: begin
          drive = ramp_drive(a, rel_ang, fwd_ang);
          if (a >= fwd_ang) begin
            sol       = tas_pkg::SOL_OFF;
            launch_ph = tas_pkg::LN_RETURN;
          end
        end
        tas_pkg::LN_RETURN: begin
          drive = -(16'(return_drv));
          if (a <= slow_ang) launch_ph = tas_pkg::LN_SLOW;
        end
        tas_pkg::LN_SLOW: begin
          drive = clamp16(-longint'(ramp_drive(a, slow_ang, home_ang)));
          if (a <= home_ang) launch_ph = tas_pkg::LN_DONE;
        end
        default: clear_arm();
      endcase
    endfunction

    // Advance the arm by one accepted tick and queue the command it yields
    function void take_tick(logic signed [15:0] a, logic ov, logic [1:0] ord);
      arm_cmd_t c;
      if (ov) order = ord;
      case (order)
        tas_pkg::ORD_STOP:   clear_arm();
        tas_pkg::ORD_LOAD:   load_tick(a);
        tas_pkg::ORD_LAUNCH: launch_tick(a);
        default: ;
      endcase
      if (a > tas_pkg::SAFE_HIGH || a < tas_pkg::SAFE_LOW) clear_arm();
      c.mode      = mode;
      c.target    = setpoint;
      c.drive     = drive;
      c.sol       = sol;
      c.load_ph   = load_ph;
      c.launch_ph = launch_ph;
      c.lift      = lift_cnt;
      due_cmds.push_back(c);
    endfunction

    task report(string msg);
      $display("mismatch at word %0d: %s", checked, msg);
      errors++;
    endtask

    task match_command(arm_cmd_t got);
      arm_cmd_t want;
      if (due_cmds.size() == 0) begin
        report("command word with none expected");
      end else begin
        want = due_cmds.pop_front();
        if (got.mode !== want.mode)
          report($sformatf("motor_mode got %0d expected %0d", got.mode, want.mode));
        if (got.target !== want.target)
          report($sformatf("target_angle got %0d expected %0d", got.target, want.target));
        if (got.drive !== want.drive)
          report($sformatf("drive got %0d expected %0d", got.drive, want.drive));
        if (got.sol !== want.sol)
          report($sformatf("solenoid_cmd got %0d expected %0d", got.sol, want.sol));
        if (got.load_ph !== want.load_ph)
          report($sformatf("load_step got %0d expected %0d", got.load_ph, want.load_ph));
        if (got.launch_ph !== want.launch_ph)
          report($sformatf("launch_step got %0d expected %0d", got.launch_ph,
                           want.launch_ph));
        if (got.lift !== want.lift)
          report($sformatf("lift_ticks got %0d expected %0d", got.lift, want.lift));
      end
      checked++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tas_in_if  in_if ();
  tas_out_if out_if ();

  arm_command_board board = new();
  bit calm = 1'b0;
  bit feeding = 1'b0;
  int ticks_sent = 0;

  throw_arm_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Gap length: mostly none or short, a few long; none at all in calm stretches
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random angle in a range, kept inside the safety window where the range allows
  function automatic logic signed [15:0] angle_in(longint lo, longint hi);
    longint l, h;
    l = (lo < -1200) ? -1200 : lo;
    h = (hi > 1200) ? 1200 : hi;
    if (l > h) return board.clamp16(lo);
    return 16'(l + longint'($urandom_range(0, int'(h - l))));
  endfunction

  // Offer one tick word and hold it until the block takes it
  task automatic send_tick(input logic signed [15:0] a, input logic ov,
                           input logic [1:0] ord);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      if (feeding) begin
        in_if.valid <= 1'b0;
        in_if.angle <= 16'($urandom);
        feeding = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.angle       <= a;
    in_if.order_valid <= ov;
    in_if.new_order   <= ord;
    feeding = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.take_tick(a, ov, ord);
    ticks_sent++;
  endtask

  // Stop feeding and wait until every queued command word has come back
  task automatic wait_drained();
    if (feeding) begin
      in_if.valid <= 1'b0;
      feeding = 1'b0;
    end
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // Write the full register set; the block must be idle
  task automatic program_arm(input logic signed [15:0] pk, lf, rl, fw, sl, hm,
                             input logic [7:0] ld, rd);
    write_reg(tas_pkg::REG_PICK, pk);
    write_reg(tas_pkg::REG_LIFT, lf);
    write_reg(tas_pkg::REG_RELEASE, rl);
    write_reg(tas_pkg::REG_FWD, fw);
    write_reg(tas_pkg::REG_SLOW, sl);
    write_reg(tas_pkg::REG_HOME, hm);
    write_reg(tas_pkg::REG_LDRIVE, {8'($urandom), ld});
    write_reg(tas_pkg::REG_RDRIVE, {8'($urandom), rd});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_arm();
    int rl, fw, sl, hm;
    rl = int'($urandom_range(0, 800)) - 200;
    fw = rl + int'($urandom_range(0, 500));
    sl = int'($urandom_range(0, 1000)) - 300;
    hm = sl - int'($urandom_range(0, 400));
    program_arm(16'(int'($urandom_range(0, 700)) - 600),
                16'(int'($urandom_range(0, 1000)) - 800),
                16'(rl), 16'(fw), 16'(sl), 16'(hm), 8'($urandom), 8'($urandom));
  endtask

  // Tick inside a sequence: mostly no new order, now and then a stray one
  task automatic episode_tick(input logic signed [15:0] a);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) send_tick(16'($urandom), 1'($urandom), 2'($urandom));
    else if (r < 6) send_tick(a, 1'b1, 2'($urandom));
    else send_tick(a, 1'b0, 2'($urandom));
  endtask

  // Grip, close, lift for the full hold, then finish
  task automatic load_run();
    send_tick(angle_in(board.pick_ang + 1, board.pick_ang + 300), 1'b1,
              tas_pkg::ORD_LOAD);
    repeat ($urandom_range(0, 3))
      episode_tick(angle_in(board.pick_ang + 1, board.pick_ang + 300));
    episode_tick(angle_in(board.pick_ang - 300, board.pick_ang));
    episode_tick(angle_in(-1200, 1200));
    repeat (tas_pkg::LIFT_TICKS)
      episode_tick(angle_in(board.lift_ang - 100, board.lift_ang + 100));
    episode_tick(angle_in(-1200, 1200));
  endtask

  // Swing up to release, ramp to the forward stop, return and ramp home
  task automatic launch_run();
    send_tick(angle_in(board.rel_ang - 300, board.rel_ang - 1), 1'b1,
              tas_pkg::ORD_LAUNCH);
    repeat ($urandom_range(0, 3))
      episode_tick(angle_in(board.rel_ang - 300, board.rel_ang - 1));
    episode_tick(angle_in(board.rel_ang, board.rel_ang + 50));
    repeat ($urandom_range(0, 4)) episode_tick(angle_in(board.rel_ang - 50, board.fwd_ang - 1));
    episode_tick(angle_in(board.fwd_ang, board.fwd_ang + 100));
    repeat ($urandom_range(0, 4)) episode_tick(angle_in(board.slow_ang + 1, board.fwd_ang));
    episode_tick(angle_in(board.slow_ang - 100, board.slow_ang));
    repeat ($urandom_range(0, 4)) episode_tick(angle_in(board.home_ang + 1, board.slow_ang + 50));
    episode_tick(angle_in(board.home_ang - 100, board.home_ang));
    episode_tick(angle_in(-1200, 1200));
  endtask

  // Unstructured ticks: any angle, any order, safety edges
  task automatic noise_run();
    int r;
    logic signed [15:0] a;
    repeat ($urandom_range(4, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 40) a = 16'($urandom);
      else if (r < 60) a = $urandom_range(0, 1) ? 16'($urandom_range(1195, 1205))
                                                : -16'($urandom_range(1195, 1205));
      else a = angle_in(-1200, 1200);
      send_tick(a, 1'($urandom), 2'($urandom));
    end
  endtask

  task automatic run_phase(input int count);
    int goal, r;
    goal = ticks_sent + count;
    while (ticks_sent < goal) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) load_run();
      else if (r < 75) launch_run();
      else noise_run();
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  // Directed ticks on the reset settings
  task automatic directed_ticks();
    send_tick(16'sd0, 1'b0, tas_pkg::ORD_LAUNCH);      // order ignored without its flag
    send_tick(16'sd32767, 1'b0, tas_pkg::ORD_HOLD);    // top of range trips safety
    send_tick(-16'sd32768, 1'b1, tas_pkg::ORD_STOP);
    send_tick(16'sd0, 1'b1, tas_pkg::ORD_LOAD);        // grip, solenoid open
    send_tick(-16'sd75, 1'b1, tas_pkg::ORD_HOLD);      // hold keeps everything
    send_tick(-16'sd75, 1'b1, tas_pkg::ORD_LOAD);      // at pick angle: close next
    send_tick(-16'sd75, 1'b0, tas_pkg::ORD_STOP);
    send_tick(-16'sd90, 1'b0, tas_pkg::ORD_STOP);      // first lift tick
    send_tick(16'sd1200, 1'b1, tas_pkg::ORD_LAUNCH);   // window edge, fires at once
    send_tick(16'sd600, 1'b0, tas_pkg::ORD_STOP);      // forward ramp
    send_tick(-16'sd1200, 1'b1, tas_pkg::ORD_LOAD);    // back to load, lift step kept
    send_tick(16'sd1201, 1'b0, tas_pkg::ORD_STOP);     // just outside the window
    send_tick(16'sd100, 1'b1, tas_pkg::ORD_LAUNCH);
    send_tick(16'sd470, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd700, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd720, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd300, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd260, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd150, 1'b0, tas_pkg::ORD_STOP);      // return ramp
    send_tick(16'sd60, 1'b0, tas_pkg::ORD_STOP);
    send_tick(16'sd60, 1'b0, tas_pkg::ORD_STOP);       // launch finished, stop
    send_tick(-16'sd1201, 1'b1, tas_pkg::ORD_LAUNCH);
    send_tick(-16'sd1200, 1'b1, tas_pkg::ORD_LOAD);
    send_tick(16'sd0, 1'b0, tas_pkg::ORD_STOP);
  endtask

  // Command sink: check each accepted word, stall at random
  initial begin : command_sink
    int hold;
    arm_cmd_t got;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.mode      = out_if.motor_mode;
        got.target    = out_if.target_angle;
        got.drive     = out_if.drive;
        got.sol       = out_if.solenoid_cmd;
        got.load_ph   = out_if.load_step;
        got.launch_ph = out_if.launch_step;
        got.lift      = out_if.lift_ticks;
        board.match_command(got);
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    int p;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= tas_pkg::REG_PICK;
    cfg_data_i        <= 16'd0;
    in_if.valid       <= 1'b0;
    in_if.angle       <= 16'sd0;
    in_if.order_valid <= 1'b0;
    in_if.new_order   <= tas_pkg::ORD_STOP;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_ticks();
    for (p = 0; p < 11; p++) begin
      wait_drained();
      case (p)
        0: ;
        2: program_arm(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                       8'd255, 8'd255);
        4: program_arm(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       8'd0, 8'd0);
        // flat ramps: release at the forward stop, slow at home
        6: program_arm(16'sd0, 16'sd0, 16'sd300, 16'sd300, -16'sd100, -16'sd100,
                       8'd200, 8'd17);
        // one-step ramps that saturate the drive
        8: program_arm(-16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 8'd255, 8'd255);
        default: random_arm();
      endcase
      run_phase(165);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("PASS throw_arm_sequencer");
    else
      $display("FAIL throw_arm_sequencer");
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("FAIL throw_arm_sequencer");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/tas_pkg.sv
hdl/tas_stream_if.sv
hdl/tas_divider.sv
hdl/tas_datapath.sv
hdl/tas_ctrl.sv
hdl/throw_arm_sequencer.sv
test/throw_arm_sequencer_test.sv
